[src/assert_macros.svh]
// Assertion macros used by the RTL of the timer table scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `ASSERT_ALWAYS(lbl, clk, rst_n, !(cond), msg)

`endif

[src/tws_pkg.sv]
// Package with the constants and types of the timer table scheduler.
`timescale 1ns / 1ps
`default_nettype none

package tws_pkg;

    localparam int DEF_MAX_TIMERS = 16;
    localparam int RESULT_LIMIT   = 16;
    localparam int NFIRE_W        = $clog2(RESULT_LIMIT + 1);

    localparam int FUNC_W   = 2;
    localparam int ID_W     = 4;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CREATE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NEAREST = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

    localparam logic [COUNT_W-1:0] FOREVER_RUNS = 8'd255;

    typedef struct packed {
        logic [TIME_W-1:0]  expiry;
        logic [TIME_W-1:0]  period;
        logic [COUNT_W-1:0] runs;
    } t_entry;

endpackage

`default_nettype wire

[src/tws_in_if.sv]
// Request channel of the timer table scheduler.
`timescale 1ns / 1ps
`default_nettype none

interface tws_in_if;
    logic                         valid;
    logic                         ready;
    logic [tws_pkg::FUNC_W-1:0]   func;
    logic [tws_pkg::ID_W-1:0]     timer_id;
    logic [tws_pkg::TIME_W-1:0]   interval;
    logic [tws_pkg::COUNT_W-1:0]  repeat_count;

    modport source (output valid, output func, output timer_id, output interval,
                    output repeat_count, input ready);
    modport sink   (input valid, input func, input timer_id, input interval,
                    input repeat_count, output ready);
endinterface

`default_nettype wire

[src/tws_out_if.sv]
// Result channel of the timer table scheduler.
`timescale 1ns / 1ps
`default_nettype none

interface tws_out_if;
    logic                          valid;
    logic                          ready;
    logic [tws_pkg::KIND_W-1:0]    kind;
    logic [tws_pkg::STATUS_W-1:0]  status;
    logic [tws_pkg::ID_W-1:0]      fired_id;
    logic [tws_pkg::TIME_W-1:0]    distance;
    logic                          last;

    modport source (output valid, output kind, output status, output fired_id,
                    output distance, output last, input ready);
    modport sink   (input valid, input kind, input status, input fired_id,
                    input distance, input last, output ready);
endinterface

`default_nettype wire

[src/timer_wheel_scheduler.sv]
// Top level of the timer table scheduler: sequencer, timer memory and result register.
// Tick and query scan the timer memory one entry per cycle, a tick scan only while no
// firing waits on a stalled result. Create and delete go from idle to the emit state.
// One request is worked on at a time; the read of one timer entry per cycle sets the rate.
// A new request is taken while the last result still waits in the output register.
// Reset clears the time, the active bits and the control state; the memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module timer_wheel_scheduler #(
    parameter int MAX_TIMERS = tws_pkg::DEF_MAX_TIMERS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tws_in_if.sink     i_req,
    tws_out_if.source  o_rsp
);

    localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TIMERS - 1);
    localparam logic [tws_pkg::NFIRE_W-1:0] NFIRE_MAX =
        tws_pkg::NFIRE_W'(tws_pkg::RESULT_LIMIT);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    // Timer memory, one synchronous read per cycle at the next scan index.
    tws_pkg::t_entry r_mem [MAX_TIMERS];
    tws_pkg::t_entry r_rd;
    logic            w_en;
    logic [IW-1:0]   w_addr;
    tws_pkg::t_entry w_data;

    logic [1:0]                      r_state, n_state;
    logic [MAX_TIMERS-1:0]           r_active, n_active;
    logic [tws_pkg::TIME_W-1:0]      r_time, n_time;
    logic [IW-1:0]                   r_idx, n_idx;
    logic                            r_is_query, n_is_query;
    logic                            r_found, n_found;
    logic [tws_pkg::TIME_W-1:0]      r_best, n_best;
    logic                            r_pend_valid, n_pend_valid;
    logic [IW-1:0]                   r_pend_id, n_pend_id;
    logic [tws_pkg::NFIRE_W-1:0]     r_nfire, n_nfire;

    logic [tws_pkg::KIND_W-1:0]      r_ans_kind, n_ans_kind;
    logic [tws_pkg::STATUS_W-1:0]    r_ans_status, n_ans_status;
    logic [tws_pkg::ID_W-1:0]        r_ans_id, n_ans_id;
    logic [tws_pkg::TIME_W-1:0]      r_ans_dist, n_ans_dist;

    logic                            r_out_valid, n_out_valid;
    logic [tws_pkg::KIND_W-1:0]      r_out_kind, n_out_kind;
    logic [tws_pkg::STATUS_W-1:0]    r_out_status, n_out_status;
    logic [tws_pkg::ID_W-1:0]        r_out_id, n_out_id;
    logic [tws_pkg::TIME_W-1:0]      r_out_dist, n_out_dist;
    logic                            r_out_last, n_out_last;

    logic                            in_acc;
    logic                            out_free;
    logic                            free_any;
    logic [IW-1:0]                   free_idx;
    logic [IW-1:0]                   del_idx;
    logic                            del_ok;
    logic                            hit;
    logic                            emit;
    logic                            stall;
    logic [tws_pkg::COUNT_W-1:0]     runs_next;
    logic [tws_pkg::TIME_W-1:0]      delta;

    assign in_acc   = i_req.valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.kind     = r_out_kind;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.fired_id = r_out_id;
    assign o_rsp.distance = r_out_dist;
    assign o_rsp.last     = r_out_last;

    // Lowest free entry for create.
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int k = MAX_TIMERS - 1; k >= 0; k--) begin
            if (!r_active[k]) begin
                free_any = 1'b1;
                free_idx = IW'(k);
            end
        end
    end

    assign del_idx = IW'(i_req.timer_id);
    assign del_ok  = (32'(i_req.timer_id) < 32'(MAX_TIMERS)) && r_active[del_idx];

    assign hit       = r_active[r_idx] && (r_rd.expiry == r_time);
    assign emit      = hit && !r_is_query && (r_nfire < NFIRE_MAX);
    // A firing waits while the previous one cannot leave the pending slot.
    assign stall     = emit && r_pend_valid && !out_free;
    assign runs_next = (r_rd.runs == tws_pkg::FOREVER_RUNS) ? r_rd.runs
                                                            : r_rd.runs - 8'd1;
    assign delta     = r_rd.expiry - r_time;

    always_comb begin
        n_state      = r_state;
        n_active     = r_active;
        n_time       = r_time;
        n_idx        = r_idx;
        n_is_query   = r_is_query;
        n_found      = r_found;
        n_best       = r_best;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_nfire      = r_nfire;
        n_ans_kind   = r_ans_kind;
        n_ans_status = r_ans_status;
        n_ans_id     = r_ans_id;
        n_ans_dist   = r_ans_dist;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_kind   = r_out_kind;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_dist   = r_out_dist;
        n_out_last   = r_out_last;
        w_en         = 1'b0;
        w_addr       = r_idx;
        w_data       = r_rd;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_ans_id   = '0;
                    n_ans_dist = '0;
                    case (i_req.func)
                        tws_pkg::FUNC_TICK: begin
                            n_time       = r_time + 32'd1;
                            n_idx        = '0;
                            n_is_query   = 1'b0;
                            n_pend_valid = 1'b0;
                            n_nfire      = '0;
                            n_state      = S_SCAN;
                        end
                        tws_pkg::FUNC_QUERY: begin
                            n_idx      = '0;
                            n_is_query = 1'b1;
                            n_found    = 1'b0;
                            n_best     = '0;
                            n_state    = S_SCAN;
                        end
                        tws_pkg::FUNC_CREATE: begin
                            n_ans_kind = tws_pkg::KIND_CREATE;
                            if ((i_req.interval == '0) || (i_req.repeat_count == '0)) begin
                                n_ans_status = tws_pkg::ST_INVALID;
                            end else if (!free_any) begin
                                n_ans_status = tws_pkg::ST_FULL;
                            end else begin
                                n_ans_status       = tws_pkg::ST_OK;
                                n_ans_id           = tws_pkg::ID_W'(free_idx);
                                n_active[free_idx] = 1'b1;
                                w_en               = 1'b1;
                                w_addr             = free_idx;
                                w_data.expiry      = r_time + i_req.interval;
                                w_data.period      = i_req.interval;
                                w_data.runs        = i_req.repeat_count;
                            end
                            n_state = S_EMIT;
                        end
                        tws_pkg::FUNC_DELETE: begin
                            n_ans_kind = tws_pkg::KIND_DELETE;
                            if (del_ok) begin
                                n_ans_status      = tws_pkg::ST_OK;
                                n_active[del_idx] = 1'b0;
                            end else begin
                                n_ans_status = tws_pkg::ST_INVALID;
                            end
                            n_state = S_EMIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (!stall) begin
                    if (r_is_query) begin
                        if (r_active[r_idx] && (!r_found || (delta < r_best))) begin
                            n_best  = delta;
                            n_found = 1'b1;
                        end
                    end else if (hit) begin
                        w_en        = 1'b1;
                        w_data.runs = runs_next;
                        if (runs_next == '0) begin
                            n_active[r_idx] = 1'b0;
                        end else begin
                            w_data.expiry = r_rd.expiry + r_rd.period;
                        end
                        if (emit) begin
                            // The earlier firing is known not to be the last one now.
                            if (r_pend_valid) begin
                                n_out_valid  = 1'b1;
                                n_out_kind   = tws_pkg::KIND_FIRED;
                                n_out_status = tws_pkg::ST_OK;
                                n_out_id     = tws_pkg::ID_W'(r_pend_id);
                                n_out_dist   = '0;
                                n_out_last   = 1'b0;
                            end
                            n_pend_valid = 1'b1;
                            n_pend_id    = r_idx;
                            n_nfire      = r_nfire + tws_pkg::NFIRE_W'(1);
                        end
                    end

                    if (r_idx == LAST_IDX) begin
                        n_idx = '0;
                        if (r_is_query) begin
                            n_ans_kind   = tws_pkg::KIND_NEAREST;
                            n_ans_status = n_found ? tws_pkg::ST_OK : tws_pkg::ST_EMPTY;
                            n_ans_dist   = n_found ? n_best : '0;
                            n_state      = S_EMIT;
                        end else begin
                            n_state = S_FLUSH;
                        end
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end

            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = tws_pkg::KIND_FIRED;
                    n_out_status = tws_pkg::ST_OK;
                    n_out_id     = tws_pkg::ID_W'(r_pend_id);
                    n_out_dist   = '0;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_ans_kind;
                    n_out_status = r_ans_status;
                    n_out_id     = r_ans_id;
                    n_out_dist   = r_ans_dist;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd <= r_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active     <= '0;
            r_time       <= '0;
            r_pend_valid <= 1'b0;
            r_nfire      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_time       <= n_time;
            r_pend_valid <= n_pend_valid;
            r_nfire      <= n_nfire;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_is_query   <= n_is_query;
        r_found      <= n_found;
        r_best       <= n_best;
        r_pend_id    <= n_pend_id;
        r_ans_kind   <= n_ans_kind;
        r_ans_status <= n_ans_status;
        r_ans_id     <= n_ans_id;
        r_ans_dist   <= n_ans_dist;
        r_out_kind   <= n_out_kind;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_dist   <= n_out_dist;
        r_out_last   <= n_out_last;
    end

    `ASSERT_ALWAYS(a_tick_advances, i_clk, i_rst_n,
        (in_acc && (i_req.func == tws_pkg::FUNC_TICK)) |=> (r_time == $past(r_time) + 32'd1),
        "tick request did not advance the time by one")
    `ASSERT_NEVER(a_fire_limit, i_clk, i_rst_n, r_nfire > NFIRE_MAX,
        "more firings counted than one tick may emit")
    `ASSERT_ALWAYS(a_pend_scope, i_clk, i_rst_n,
        r_pend_valid |-> ((r_state == S_SCAN) || (r_state == S_FLUSH)),
        "pending firing held outside a tick scan")
    `ASSERT_ALWAYS(a_open_is_fired, i_clk, i_rst_n,
        (r_out_valid && !r_out_last) |-> (r_out_kind == tws_pkg::KIND_FIRED),
        "only firings may be followed by further results of the same request")

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the timer table scheduler: directed, full-table and random traffic.
module testbench;

    localparam int NUM_TIMERS   = tws_pkg::DEF_MAX_TIMERS;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 10;
    localparam logic [12:0] RX_STALL_PATTERN = 13'b1011001110001;

    typedef enum int {RX_ALWAYS, RX_PATTERN, RX_RANDOM, RX_SLOW} t_rx_mode;

    typedef struct packed {
        logic [tws_pkg::KIND_W-1:0]   kind;
        logic [tws_pkg::STATUS_W-1:0] status;
        logic [tws_pkg::ID_W-1:0]     fired_id;
        logic [tws_pkg::TIME_W-1:0]   distance;
        logic                         last;
    } t_timer_rsp;

    logic clk;
    logic rst_n;

    tws_in_if  req_if ();
    tws_out_if rsp_if ();

    timer_wheel_scheduler dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // Local copy of the timer table.
    logic [tws_pkg::TIME_W-1:0]  now_ticks;
    logic                        timer_on     [NUM_TIMERS];
    logic [tws_pkg::TIME_W-1:0]  timer_due    [NUM_TIMERS];
    logic [tws_pkg::TIME_W-1:0]  timer_period [NUM_TIMERS];
    logic [tws_pkg::COUNT_W-1:0] timer_runs   [NUM_TIMERS];

    t_timer_rsp expected_rsp [$];

    int       error_count;
    int       results_checked;
    int       idle_cycles;
    int       req_count [4];
    int       firings_total;
    int       most_firings;
    int       full_refusals;
    int       gap_max;
    int       burst_max;
    int       burst_left;
    bit       req_raised;
    t_rx_mode rx_mode;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    function automatic void push_rsp(input logic [tws_pkg::KIND_W-1:0] kind,
                                     input logic [tws_pkg::STATUS_W-1:0] status,
                                     input logic [tws_pkg::ID_W-1:0] id,
                                     input logic [tws_pkg::TIME_W-1:0] delta,
                                     input logic last);
        t_timer_rsp r;
        r.kind     = kind;
        r.status   = status;
        r.fired_id = id;
        r.distance = delta;
        r.last     = last;
        expected_rsp.push_back(r);
    endfunction

    // Applies one accepted request to the local table and queues its results.
    function automatic void predict_timer_request(input logic [tws_pkg::FUNC_W-1:0] func,
                                                  input logic [tws_pkg::ID_W-1:0] id,
                                                  input logic [tws_pkg::TIME_W-1:0] interval,
                                                  input logic [tws_pkg::COUNT_W-1:0] count);
        logic [tws_pkg::ID_W-1:0]   due_ids [tws_pkg::RESULT_LIMIT];
        logic [tws_pkg::TIME_W-1:0] best;
        logic                       found;
        int                         n_due;
        int                         slot;

        n_due = 0;
        slot  = -1;
        found = 1'b0;
        best  = '0;
        case (func)
            tws_pkg::FUNC_TICK: begin
                now_ticks = now_ticks + 32'd1;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (timer_on[i] && timer_due[i] == now_ticks) begin
                        // Firings beyond the result limit still update the entry.
                        if (n_due < tws_pkg::RESULT_LIMIT) begin
                            due_ids[n_due] = tws_pkg::ID_W'(i);
                            n_due++;
                        end
                        if (timer_runs[i] != tws_pkg::FOREVER_RUNS) begin
                            timer_runs[i] = timer_runs[i] - 8'd1;
                        end
                        if (timer_runs[i] == '0) begin
                            timer_on[i] = 1'b0;
                        end else begin
                            timer_due[i] = timer_due[i] + timer_period[i];
                        end
                    end
                end
                for (int k = 0; k < n_due; k++) begin
                    push_rsp(tws_pkg::KIND_FIRED, tws_pkg::ST_OK, due_ids[k], '0,
                             k == n_due - 1);
                end
                firings_total += n_due;
                if (n_due > most_firings) begin
                    most_firings = n_due;
                end
            end
            tws_pkg::FUNC_CREATE: begin
                if (interval == '0 || count == '0) begin
                    push_rsp(tws_pkg::KIND_CREATE, tws_pkg::ST_INVALID, '0, '0, 1'b1);
                end else begin
                    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
                        if (!timer_on[i]) begin
                            slot = i;
                        end
                    end
                    if (slot < 0) begin
                        full_refusals++;
                        push_rsp(tws_pkg::KIND_CREATE, tws_pkg::ST_FULL, '0, '0, 1'b1);
                    end else begin
                        timer_on[slot]     = 1'b1;
                        timer_due[slot]    = now_ticks + interval;
                        timer_period[slot] = interval;
                        timer_runs[slot]   = count;
                        push_rsp(tws_pkg::KIND_CREATE, tws_pkg::ST_OK,
                                 tws_pkg::ID_W'(slot), '0, 1'b1);
                    end
                end
            end
            tws_pkg::FUNC_DELETE: begin
                if (int'(id) >= NUM_TIMERS || !timer_on[id]) begin
                    push_rsp(tws_pkg::KIND_DELETE, tws_pkg::ST_INVALID, '0, '0, 1'b1);
                end else begin
                    timer_on[id] = 1'b0;
                    push_rsp(tws_pkg::KIND_DELETE, tws_pkg::ST_OK, '0, '0, 1'b1);
                end
            end
            default: begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (timer_on[i] && (!found || timer_due[i] - now_ticks < best)) begin
                        best  = timer_due[i] - now_ticks;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    push_rsp(tws_pkg::KIND_NEAREST, tws_pkg::ST_OK, '0, best, 1'b1);
                end else begin
                    push_rsp(tws_pkg::KIND_NEAREST, tws_pkg::ST_EMPTY, '0, '0, 1'b1);
                end
            end
        endcase
    endfunction

    // Drives one request, waits for its acceptance, then maybe pauses between bursts.
    task automatic send_request(input logic [tws_pkg::FUNC_W-1:0] func,
                                input logic [tws_pkg::ID_W-1:0] id,
                                input logic [tws_pkg::TIME_W-1:0] interval,
                                input logic [tws_pkg::COUNT_W-1:0] count);
        req_if.valid        <= 1'b1;
        req_if.func         <= func;
        req_if.timer_id     <= id;
        req_if.interval     <= interval;
        req_if.repeat_count <= count;
        req_raised = 1'b1;
        do @(posedge clk); while (!req_if.ready);
        predict_timer_request(func, id, interval, count);
        req_count[func]++;
        if (burst_left > 0) begin
            burst_left--;
        end else if (gap_max > 0) begin
            req_if.valid <= 1'b0;
            req_raised = 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clk);
            burst_left = $urandom_range(0, burst_max);
        end
    endtask

    task automatic test_basic_operations();
        gap_max   = 3;
        burst_max = 2;
        rx_mode   = RX_PATTERN;
        send_request(tws_pkg::FUNC_TICK, 4'h0, 32'd0, 8'd0);
        send_request(tws_pkg::FUNC_QUERY, 4'h0, 32'd0, 8'd0);
        send_request(tws_pkg::FUNC_CREATE, 4'h0, 32'd0, 8'd3);
        send_request(tws_pkg::FUNC_CREATE, 4'h0, 32'd5, 8'd0);
        send_request(tws_pkg::FUNC_DELETE, 4'hF, 32'd0, 8'd0);
        send_request(tws_pkg::FUNC_CREATE, 4'h0, 32'd1, 8'd1);
        // Expiry wraps past the top of the time range.
        send_request(tws_pkg::FUNC_CREATE, 4'h0, 32'hFFFF_FFFF, tws_pkg::FOREVER_RUNS);
        send_request(tws_pkg::FUNC_CREATE, 4'h0, 32'd3, tws_pkg::FOREVER_RUNS);
        send_request(tws_pkg::FUNC_CREATE, 4'h0, 32'd2, 8'd2);
        send_request(tws_pkg::FUNC_QUERY, 4'h0, 32'd0, 8'd0);
        repeat (4) send_request(tws_pkg::FUNC_TICK, 4'h0, 32'd0, 8'd0);
        send_request(tws_pkg::FUNC_DELETE, 4'h1, 32'd0, 8'd0);
        send_request(tws_pkg::FUNC_DELETE, 4'h1, 32'd0, 8'd0);
        send_request(tws_pkg::FUNC_QUERY, 4'h0, 32'd0, 8'd0);
        send_request(tws_pkg::FUNC_CREATE, 4'hF, 32'h8000_0000, 8'd254);
        send_request(tws_pkg::FUNC_CREATE, 4'h0, 32'hFFFF_FFFE, 8'd1);
        send_request(tws_pkg::FUNC_QUERY, 4'hF, 32'hFFFF_FFFF, 8'hFF);
        send_request(tws_pkg::FUNC_DELETE, 4'h0, 32'd0, 8'd0);
        send_request(tws_pkg::FUNC_DELETE, 4'h1, 32'd0, 8'd0);
        send_request(tws_pkg::FUNC_CREATE, 4'hA, 32'd1, 8'd3);
        repeat (3) send_request(tws_pkg::FUNC_TICK, 4'h5, 32'd0, 8'd0);
    endtask

    // Every entry due on the same tick gives the longest result burst.
    task automatic test_full_table();
        gap_max = 0;
        rx_mode = RX_SLOW;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (timer_on[i]) begin
                send_request(tws_pkg::FUNC_DELETE, tws_pkg::ID_W'(i), 32'd0, 8'd0);
            end
        end
        repeat (NUM_TIMERS) send_request(tws_pkg::FUNC_CREATE, 4'h0, 32'd4, 8'd2);
        send_request(tws_pkg::FUNC_CREATE, 4'h0, 32'd9, 8'd1);
        send_request(tws_pkg::FUNC_QUERY, 4'h0, 32'd0, 8'd0);
        rx_mode = RX_RANDOM;
        repeat (8) send_request(tws_pkg::FUNC_TICK, 4'h0, 32'd0, 8'd0);
        send_request(tws_pkg::FUNC_QUERY, 4'h0, 32'd0, 8'd0);
    endtask

    task automatic test_random_traffic(input int n_items, input int gap_limit,
                                       input int burst_limit, input t_rx_mode rx);
        logic [tws_pkg::ID_W-1:0]    live_ids [$];
        logic [tws_pkg::ID_W-1:0]    id;
        logic [tws_pkg::TIME_W-1:0]  interval;
        logic [tws_pkg::COUNT_W-1:0] count;
        int                          pick;

        gap_max   = gap_limit;
        burst_max = burst_limit;
        rx_mode   = rx;
        repeat (n_items) begin
            pick     = $urandom_range(0, 99);
            id       = tws_pkg::ID_W'($urandom_range(0, 15));
            interval = $urandom;
            count    = tws_pkg::COUNT_W'($urandom_range(0, 255));
            if (pick < 45) begin
                send_request(tws_pkg::FUNC_TICK, id, interval, count);
            end else if (pick < 75) begin
                // Mostly short intervals and often few runs, so that timers fire and free.
                case ($urandom_range(0, 9))
                    0:       interval = '0;
                    1:       ;
                    2:       interval = $urandom_range(13, 200);
                    default: interval = $urandom_range(1, 12);
                endcase
                case ($urandom_range(0, 9))
                    0:          count = '0;
                    1, 2:       count = tws_pkg::FOREVER_RUNS;
                    3, 4, 5:    count = tws_pkg::COUNT_W'($urandom_range(1, 254));
                    default:    count = tws_pkg::COUNT_W'($urandom_range(1, 3));
                endcase
                send_request(tws_pkg::FUNC_CREATE, id, interval, count);
            end else if (pick < 88) begin
                live_ids.delete();
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (timer_on[i]) begin
                        live_ids.push_back(tws_pkg::ID_W'(i));
                    end
                end
                if (live_ids.size() > 0 && $urandom_range(0, 3) != 0) begin
                    id = live_ids[$urandom_range(0, live_ids.size() - 1)];
                end
                send_request(tws_pkg::FUNC_DELETE, id, interval, count);
            end else begin
                send_request(tws_pkg::FUNC_QUERY, id, interval, count);
            end
        end
    endtask

    // Result side ready pattern.
    initial begin
        int rx_phase;
        rx_phase = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            case (rx_mode)
                RX_ALWAYS:  rsp_if.ready <= 1'b1;
                RX_PATTERN: begin
                    rsp_if.ready <= RX_STALL_PATTERN[rx_phase];
                    rx_phase = (rx_phase + 1) % 13;
                end
                RX_RANDOM:  rsp_if.ready <= ($urandom_range(0, 3) != 0);
                default:    rsp_if.ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    always @(posedge clk) begin : check_results
        t_timer_rsp got;
        t_timer_rsp want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            got.kind     = rsp_if.kind;
            got.status   = rsp_if.status;
            got.fired_id = rsp_if.fired_id;
            got.distance = rsp_if.distance;
            got.last     = rsp_if.last;
            results_checked++;
            if (expected_rsp.size() == 0) begin
                note_error($sformatf({"unexpected result kind=%0d status=%0d id=%0d ",
                                      "dist=%h last=%0d"},
                                     got.kind, got.status, got.fired_id, got.distance,
                                     got.last));
            end else begin
                want = expected_rsp.pop_front();
                if (got !== want) begin
                    note_error($sformatf({"mismatch: expected kind=%0d status=%0d id=%0d ",
                                          "dist=%h last=%0d, got kind=%0d status=%0d id=%0d ",
                                          "dist=%h last=%0d"},
                                         want.kind, want.status, want.fired_id, want.distance,
                                         want.last, got.kind, got.status, got.fired_id,
                                         got.distance, got.last));
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    initial begin
        now_ticks       = '0;
        error_count     = 0;
        results_checked = 0;
        idle_cycles     = 0;
        firings_total   = 0;
        most_firings    = 0;
        full_refusals   = 0;
        burst_left      = 0;
        req_raised      = 1'b0;
        rx_mode         = RX_ALWAYS;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            timer_on[i] = 1'b0;
        end
        for (int f = 0; f < 4; f++) begin
            req_count[f] = 0;
        end
        rst_n               <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.func         <= tws_pkg::FUNC_TICK;
        req_if.timer_id     <= '0;
        req_if.interval     <= '0;
        req_if.repeat_count <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_operations();
        test_full_table();
        test_random_traffic(50, 6, 4, RX_RANDOM);
        test_random_traffic(50, 0, 0, RX_PATTERN);
        test_random_traffic(50, 15, 8, RX_ALWAYS);
        test_random_traffic(50, 4, 12, RX_SLOW);

        if (req_raised) begin
            req_if.valid <= 1'b0;
        end
        while (expected_rsp.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d ticks, %0d creates, %0d deletes, %0d queries.",
                 req_count[tws_pkg::FUNC_TICK] + req_count[tws_pkg::FUNC_CREATE]
                 + req_count[tws_pkg::FUNC_DELETE] + req_count[tws_pkg::FUNC_QUERY],
                 req_count[tws_pkg::FUNC_TICK], req_count[tws_pkg::FUNC_CREATE],
                 req_count[tws_pkg::FUNC_DELETE], req_count[tws_pkg::FUNC_QUERY]);
        $display("Checked %0d results, %0d firings (up to %0d in one tick), %0d full refusals.",
                 results_checked, firings_total, most_firings, full_refusals);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("%0d failures in total", error_count);
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/tws_pkg.sv
src/tws_in_if.sv
src/tws_out_if.sv
src/timer_wheel_scheduler.sv
tb/testbench.sv
